[hdl/hkst_pkg.sv]
// Package for the keyboard key slot table: field widths, slot count,
// command and operation codes, and the queued operation type.
// No dependencies.
package hkst_pkg;

  localparam int KEY_SLOTS = 6;
  localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CNT_W     = $clog2(KEY_SLOTS + 1);

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 8;
  localparam int MOD_W   = 8;
  localparam int SLOT_W  = 3;

  localparam int Q_PTR_W = 1;
  localparam int Q_DEPTH = 1 << Q_PTR_W;

  localparam logic [CMD_W-1:0] CMD_PRESS       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 2'd2;

  localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [MOD_W-1:0] mod_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_PRESS_KEY,
    OP_SET_MOD,
    OP_RELEASE_KEY,
    OP_CLR_MOD,
    OP_CLEAR_ALL
  } op_t;

  typedef struct packed {
    op_t  op;
    key_t key;
    mod_t mask;
  } item_t;

endpackage

[hdl/hkst_if.sv]
// Valid/ready channel interfaces for command beats and slot result beats.
// Depends on hkst_pkg.
interface hkst_in_if
  import hkst_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  key_t             key_code;
  mod_t             modifier_mask;

  modport source(output valid, output cmd, output key_code, output modifier_mask,
                 input ready);
  modport sink(input valid, input cmd, input key_code, input modifier_mask,
               output ready);
endinterface

interface hkst_out_if
  import hkst_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  key_t              slot_key;
  mod_t              modifiers;
  logic              last;

  modport source(output valid, output slot_index, output slot_key, output modifiers,
                 output last, input ready);
  modport sink(input valid, input slot_index, input slot_key, input modifiers,
               input last, output ready);
endinterface

[hdl/hkst_front.sv]
// Front end: accepts command beats and classifies them into table operations.
// Depends on hkst_pkg and hkst_in_if.
module hkst_front
  import hkst_pkg::*;
(
  hkst_in_if.sink in_ch,
  output logic    push_valid,
  output item_t   push_item,
  input  logic    push_ready
);

  always_comb begin
    push_item.key  = in_ch.key_code;
    push_item.mask = in_ch.modifier_mask;
    case (in_ch.cmd)
      CMD_PRESS: begin
        push_item.op = (in_ch.key_code != KEY_NONE) ? OP_PRESS_KEY : OP_SET_MOD;
      end
      CMD_RELEASE: begin
        push_item.op = (in_ch.key_code != KEY_NONE) ? OP_RELEASE_KEY : OP_CLR_MOD;
      end
      CMD_RELEASE_ALL: begin
        push_item.op = OP_CLEAR_ALL;
      end
      default: begin
        push_item.op = OP_NOP;
      end
    endcase
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

[hdl/hkst_queue.sv]
// Two-entry operation queue between the front end and the table back end.
// Depends on hkst_pkg.
module hkst_queue
  import hkst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  item_t              slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;
  logic               push;
  logic               pop;

  assign push_ready = (count_r != (Q_PTR_W + 1)'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (Q_PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (Q_PTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[hdl/hkst_back.sv]
// Back end: applies one operation to the key table and modifier byte, then
// emits the report one slot beat at a time. Depends on hkst_pkg and hkst_out_if.
module hkst_back
  import hkst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  input  item_t       pop_item,
  output logic        pop_ready,
  hkst_out_if.source  out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  key_t             held_r   [KEY_SLOTS];
  key_t             held_nxt [KEY_SLOTS];
  key_t             packed_keys [KEY_SLOTS];
  mod_t             mod_r;
  mod_t             mod_nxt;
  logic [IDX_W-1:0] emit_cnt_r;
  logic [IDX_W-1:0] emit_cnt_nxt;
  logic [CNT_W-1:0] fill;
  logic             hit;
  logic             placed;
  logic             emit_last;
  logic [7:0]       idx_ext;

  assign pop_ready = (state_r == ST_IDLE);
  assign emit_last = (emit_cnt_r == IDX_W'(KEY_SLOTS - 1));
  assign idx_ext   = 8'(emit_cnt_r);

  assign out_ch.valid      = (state_r == ST_EMIT);
  assign out_ch.slot_index = idx_ext[SLOT_W-1:0];
  assign out_ch.slot_key   = held_r[emit_cnt_r];
  assign out_ch.modifiers  = mod_r;
  assign out_ch.last       = emit_last;

  always_comb begin
    held_nxt    = held_r;
    mod_nxt     = mod_r;
    packed_keys = '{default: KEY_NONE};
    hit         = 1'b0;
    placed      = 1'b0;
    fill        = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_r[i] == pop_item.key) begin
        hit = 1'b1;
      end
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_r[i] != KEY_NONE && held_r[i] != pop_item.key) begin
        packed_keys[fill[IDX_W-1:0]] = held_r[i];
        fill = fill + CNT_W'(1);
      end
    end
    case (pop_item.op)
      OP_PRESS_KEY: begin
        mod_nxt = mod_r | pop_item.mask;
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!hit && !placed && held_r[i] == KEY_NONE) begin
            held_nxt[i] = pop_item.key;
            placed      = 1'b1;
          end
        end
      end
      OP_SET_MOD: begin
        mod_nxt = mod_r | pop_item.mask;
      end
      OP_RELEASE_KEY: begin
        mod_nxt  = mod_r & ~pop_item.mask;
        held_nxt = packed_keys;
      end
      OP_CLR_MOD: begin
        mod_nxt = mod_r & ~pop_item.mask;
      end
      OP_CLEAR_ALL: begin
        mod_nxt  = '0;
        held_nxt = '{default: KEY_NONE};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    emit_cnt_nxt = emit_cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          state_nxt    = ST_EMIT;
          emit_cnt_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            emit_cnt_nxt = emit_cnt_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      emit_cnt_r <= '0;
      mod_r      <= '0;
      held_r     <= '{default: KEY_NONE};
    end else begin
      state_r    <= state_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      if (state_r == ST_IDLE && pop_valid) begin
        mod_r  <= mod_nxt;
        held_r <= held_nxt;
      end
    end
  end

endmodule

[hdl/hid_keyboard_key_slot_table_unit.sv]
// Keyboard report keeper: modifier byte plus a packed table of KEY_SLOTS key codes.
// The first slot beat appears in the cycle after the command leaves the queue; each
// command beat is registered in the queue, then applied in the back end, which then emits
// one beat per slot and takes the next command only after the last beat is taken.
// Reset (rst_n low, synchronous): table and modifiers cleared, queue emptied.
// Depends on hkst_pkg, hkst_if, hkst_front, hkst_queue, hkst_back.
module hid_keyboard_key_slot_table_unit
  import hkst_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hkst_in_if.sink      in_ch,
  hkst_out_if.source   out_ch
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  hkst_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  hkst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  hkst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

[bench/hid_keyboard_key_slot_table_unit_tb.sv]
// Testbench for hid_keyboard_key_slot_table_unit: drives press, release and clear commands
// and checks every slot beat of each report against a predictor kept in the bench.
// Depends on hkst_pkg, hkst_if and the RTL of the unit.
module hid_keyboard_key_slot_table_unit_tb;
  import hkst_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 400;
  localparam int POOL_SIZE    = 8;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    key_t              slot_key;
    mod_t              modifiers;
    logic              last;
  } slot_beat_t;

  logic clk;
  logic rst_n;

  hkst_in_if  in_ch();
  hkst_out_if out_ch();

  hid_keyboard_key_slot_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_t       held_keys_m[KEY_SLOTS];
  mod_t       modifier_m;
  slot_beat_t report_slots_q[$];
  key_t       key_pool[POOL_SIZE];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  bit         idle_on = 1'b0;
  int         hold_len = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void apply_key_cmd(input logic [CMD_W-1:0] cmd, input key_t code,
                                        input mod_t mask);
    key_t       repacked[KEY_SLOTS];
    int         n;
    bit         found;
    bit         placed;
    slot_beat_t beat;
    case (cmd)
      CMD_PRESS: begin
        modifier_m = modifier_m | mask;
        if (code != KEY_NONE) begin
          found = 1'b0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (held_keys_m[i] == code) found = 1'b1;
          end
          placed = 1'b0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (!found && !placed && held_keys_m[i] == KEY_NONE) begin
              held_keys_m[i] = code;
              placed = 1'b1;
            end
          end
        end
      end
      CMD_RELEASE: begin
        modifier_m = modifier_m & ~mask;
        if (code != KEY_NONE) begin
          n = 0;
          for (int i = 0; i < KEY_SLOTS; i++) repacked[i] = KEY_NONE;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            if (held_keys_m[i] != KEY_NONE && held_keys_m[i] != code) begin
              repacked[n] = held_keys_m[i];
              n++;
            end
          end
          held_keys_m = repacked;
        end
      end
      CMD_RELEASE_ALL: begin
        modifier_m = '0;
        for (int i = 0; i < KEY_SLOTS; i++) held_keys_m[i] = KEY_NONE;
      end
      default: ;
    endcase
    for (int i = 0; i < KEY_SLOTS; i++) begin
      beat.slot_index = SLOT_W'(i);
      beat.slot_key   = held_keys_m[i];
      beat.modifiers  = modifier_m;
      beat.last       = (i == KEY_SLOTS - 1);
      report_slots_q.push_back(beat);
    end
  endfunction

  task automatic send_key_cmd(input logic [CMD_W-1:0] cmd, input key_t code, input mod_t mask);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= cmd;
    in_ch.key_code      <= code;
    in_ch.modifier_mask <= mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_key_cmd(cmd, code, mask);
  endtask

  task automatic wait_reports_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (report_slots_q.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input slot_beat_t want,
                                 input slot_beat_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTED) begin
      $display("%s at cycle %0d: expected idx %0d key %02h mod %02h last %0b, got idx %0d key %02h mod %02h last %0b",
               what, cycle_cnt, want.slot_index, want.slot_key, want.modifiers, want.last,
               got.slot_index, got.slot_key, got.modifiers, got.last);
    end
  endtask

  always @(posedge clk) begin
    slot_beat_t got;
    slot_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.slot_index, out_ch.slot_key, out_ch.modifiers, out_ch.last};
      if (report_slots_q.size() == 0) begin
        report_mismatch("unexpected slot beat", '0, got);
      end else begin
        want = report_slots_q.pop_front();
        if (got !== want) report_mismatch("slot beat mismatch", want, got);
      end
    end
  end

  // on a hold_len request hold ready low first, else stall randomly before each beat when idle_on is set
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid && hold_len == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("hid_keyboard_key_slot_table_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic test_press_extremes();
    idle_on = 1'b1;
    send_key_cmd(CMD_PRESS, 8'hFF, 8'hFF);
    send_key_cmd(CMD_PRESS, 8'h01, 8'h00);
    send_key_cmd(CMD_PRESS, KEY_NONE, 8'h80);
    send_key_cmd(CMD_PRESS, 8'h01, 8'h01);
  endtask

  task automatic test_full_table();
    send_key_cmd(CMD_PRESS, 8'h02, 8'h00);
    send_key_cmd(CMD_PRESS, 8'h03, 8'h00);
    send_key_cmd(CMD_PRESS, 8'h04, 8'h00);
    send_key_cmd(CMD_PRESS, 8'h05, 8'h00);
    send_key_cmd(CMD_PRESS, 8'h06, 8'h01);
    send_key_cmd(CMD_PRESS, 8'h05, 8'h02);
  endtask

  task automatic test_release_cases();
    send_key_cmd(CMD_RELEASE, 8'h02, 8'hF0);
    send_key_cmd(CMD_RELEASE, 8'h77, 8'h00);
    send_key_cmd(CMD_RELEASE, KEY_NONE, 8'hFF);
    send_key_cmd(CMD_RELEASE, 8'hFF, 8'h00);
    send_key_cmd(CMD_PRESS, 8'h80, 8'h7F);
    send_key_cmd(CMD_RELEASE, 8'h80, 8'h00);
  endtask

  task automatic test_clear_and_unused();
    send_key_cmd(CMD_UNUSED, 8'hAA, 8'h55);
    send_key_cmd(CMD_RELEASE_ALL, 8'h12, 8'h34);
    send_key_cmd(CMD_RELEASE, 8'h05, 8'hFF);
    send_key_cmd(CMD_UNUSED, 8'hFF, 8'hFF);
    send_key_cmd(CMD_PRESS, 8'h2C, 8'h22);
    send_key_cmd(CMD_RELEASE_ALL, 8'hFF, 8'hFF);
  endtask

  task automatic test_random_key_traffic(input int count);
    int               r;
    logic [CMD_W-1:0] cmd;
    key_t             code;
    mod_t             mask;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      cmd = (r < 48) ? CMD_PRESS : (r < 82) ? CMD_RELEASE :
            (r < 94) ? CMD_RELEASE_ALL : CMD_UNUSED;
      r = $urandom_range(0, 99);
      if (cmd == CMD_RELEASE && r < 50) begin
        code = held_keys_m[$urandom_range(0, KEY_SLOTS - 1)];
      end else if (r < 75) begin
        code = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 85) begin
        code = KEY_NONE;
      end else begin
        code = key_t'($urandom);
      end
      mask = ($urandom_range(0, 3) == 0) ? mod_t'(0) : mod_t'($urandom);
      send_key_cmd(cmd, code, mask);
    end
  endtask

  task automatic test_sink_hold_off();
    idle_on  = 1'b0;
    hold_len = 80;
    for (int n = 0; n < 16; n++) begin
      send_key_cmd(CMD_PRESS, key_pool[n % POOL_SIZE], mod_t'($urandom));
    end
    wait_reports_drained();
    idle_on = 1'b1;
    send_key_cmd(CMD_RELEASE, key_pool[0], 8'hFF);
    send_key_cmd(CMD_RELEASE_ALL, KEY_NONE, 8'h00);
  endtask

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.cmd           <= CMD_PRESS;
    in_ch.key_code      <= KEY_NONE;
    in_ch.modifier_mask <= '0;
    rst_n               <= 1'b0;
    modifier_m = '0;
    for (int i = 0; i < KEY_SLOTS; i++) held_keys_m[i] = KEY_NONE;
    key_pool[0] = 8'hFF;
    key_pool[1] = 8'h01;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = key_t'($urandom_range(1, 255));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_press_extremes();
    test_full_table();
    test_release_cases();
    test_clear_and_unused();
    test_random_key_traffic(RANDOM_ITEMS / 2);
    test_sink_hold_off();
    test_random_key_traffic(RANDOM_ITEMS / 2);

    wait_reports_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (report_slots_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("hid_keyboard_key_slot_table_unit_tb: done, clean");
    end else begin
      $display("hid_keyboard_key_slot_table_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
